// ===== rtl/dcps_pkg.sv =====
`timescale 1ns / 1ps
package dcps_pkg;

   localparam int MAX_DETECTIONS_DEF = 32;
   localparam int COORD_BITS_DEF     = 16;
   localparam int CLASS_BITS_DEF     = 8;

   // fixed field widths on the ports
   localparam int IN_CLASS_W = 8;
   localparam int IN_COORD_W = 16;
   localparam int OUT_COORD_W = 16;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 32;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [OUT_COORD_W-1:0] out_x;
      logic [OUT_COORD_W-1:0] out_y;
      logic                   last_out;
      logic                   overflow;
   } res_type;

   typedef struct packed {
      logic    valid;
      res_type data;
   } q_push_type;

endpackage

// ===== rtl/dcps_front.sv =====
`timescale 1ns / 1ps
module dcps_front
   import dcps_pkg::*;
#(
   parameter int MAX_DETECTIONS = MAX_DETECTIONS_DEF,
   parameter int COORD_BITS     = COORD_BITS_DEF,
   parameter int CLASS_BITS     = CLASS_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [IN_CLASS_W-1:0] in_class,
   input  logic [IN_COORD_W-1:0] in_x,
   input  logic [IN_COORD_W-1:0] in_y,
   input  logic                  in_last,
   output q_push_type            push,
   input  logic                  q_full
);

   localparam int IDX_W = $clog2(MAX_DETECTIONS);
   localparam int CNT_W = $clog2(MAX_DETECTIONS + 1);
   localparam int ENT_W = CLASS_BITS + 2 * COORD_BITS;
   localparam int CW    = CLASS_BITS + IN_CLASS_W;
   localparam int XW    = COORD_BITS + IN_COORD_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DETECTIONS);

   typedef enum logic [2:0] {
      S_LOAD, S_FETCH, S_MOVE, S_CMP, S_PLACE, S_ERD, S_EWR
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in, n_ff, n_in;
   logic drop_ff, drop_in, phase_ff, phase_in, first_ff, first_in, ax_ff, ax_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, lo_ff, lo_in;
   logic [ENT_W-1:0] mov_ff, mov_in;

   // entry layout {class, y, x}
   logic [ENT_W-1:0] mem [MAX_DETECTIONS];
   logic [ENT_W-1:0] rd_data_ff;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic [ENT_W-1:0] wr_data;
   logic             wr_en;

   logic [CLASS_BITS-1:0] nb_cls, mv_cls;
   logic [COORD_BITS-1:0] nb_x, nb_y, mv_x, mv_y, dx, dy;
   logic pick, axis, gt, newrun, at_end;
   logic [CW-1:0] cls_wide;
   logic [XW-1:0] x_wide, y_wide, ox_wide, oy_wide;
   logic [CNT_W-1:0] i_next;
   logic [ENT_W-1:0] in_entry;

   assign cls_wide = CW'(in_class);
   assign x_wide   = XW'(in_x);
   assign y_wide   = XW'(in_y);
   assign in_entry = {cls_wide[CLASS_BITS-1:0], y_wide[COORD_BITS-1:0],
                      x_wide[COORD_BITS-1:0]};

   assign nb_x   = rd_data_ff[COORD_BITS-1:0];
   assign nb_y   = rd_data_ff[2*COORD_BITS-1:COORD_BITS];
   assign nb_cls = rd_data_ff[ENT_W-1:2*COORD_BITS];
   assign mv_x   = mov_ff[COORD_BITS-1:0];
   assign mv_y   = mov_ff[2*COORD_BITS-1:COORD_BITS];
   assign mv_cls = mov_ff[ENT_W-1:2*COORD_BITS];

   assign dx = (nb_x > mv_x) ? nb_x - mv_x : mv_x - nb_x;
   assign dy = (nb_y > mv_y) ? nb_y - mv_y : mv_y - nb_y;
   assign pick = dy > dx;
   // first compare of an entry picks its axis against the same neighbor
   assign axis = first_ff ? pick : ax_ff;
   assign gt = phase_ff ? (axis ? (nb_y > mv_y) : (nb_x > mv_x)) : (nb_cls > mv_cls);
   assign newrun = phase_ff && first_ff && (nb_cls != mv_cls);

   assign i_next = CNT_W'(i_ff) + CNT_W'(1);
   assign at_end = i_next == n_ff;

   assign ox_wide = XW'(nb_x);
   assign oy_wide = XW'(nb_y);

   assign in_ready = state_ff == S_LOAD;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      n_in     = n_ff;
      drop_in  = drop_ff;
      phase_in = phase_ff;
      first_in = first_ff;
      ax_in    = ax_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      lo_in    = lo_ff;
      mov_in   = mov_ff;
      rd_addr  = i_ff;
      wr_en    = 1'b0;
      wr_addr  = j_ff;
      wr_data  = mov_ff;
      push.valid         = 1'b0;
      push.data.out_x    = ox_wide[OUT_COORD_W-1:0];
      push.data.out_y    = oy_wide[OUT_COORD_W-1:0];
      push.data.last_out = at_end;
      push.data.overflow = drop_ff;

      unique case (state_ff)
         S_LOAD: begin
            if (in_valid) begin
               n_in = count_ff;
               if (count_ff < MAX_CNT) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IDX_W-1:0];
                  wr_data  = in_entry;
                  count_in = count_ff + CNT_W'(1);
                  n_in     = count_in;
               end else begin
                  drop_in = 1'b1;
               end
               if (in_last) begin
                  phase_in = 1'b0;
                  lo_in    = '0;
                  if (n_in > CNT_W'(1)) begin
                     i_in     = IDX_W'(1);
                     state_in = S_FETCH;
                  end else begin
                     i_in     = '0;
                     state_in = S_ERD;
                  end
               end
            end
         end
         S_FETCH: begin
            rd_addr  = i_ff;
            state_in = S_MOVE;
         end
         S_MOVE: begin
            rd_addr  = i_ff - IDX_W'(1);
            mov_in   = rd_data_ff;
            j_in     = i_ff;
            first_in = 1'b1;
            state_in = S_CMP;
         end
         S_CMP, S_PLACE: begin
            rd_addr = j_ff - IDX_W'(2);
            if (state_ff == S_CMP && newrun) begin
               lo_in = j_ff;
            end else if (state_ff == S_CMP && gt) begin
               wr_en    = 1'b1;
               wr_data  = rd_data_ff;
               j_in     = j_ff - IDX_W'(1);
               ax_in    = pick;
               first_in = 1'b0;
               state_in = (j_in == lo_ff) ? S_PLACE : S_CMP;
            end else begin
               wr_en = 1'b1;
            end
            if (state_in == state_ff && !(state_ff == S_CMP && gt && !newrun)) begin
               // entry placed: next insertion
               if (at_end) begin
                  if (!phase_ff) begin
                     phase_in = 1'b1;
                     i_in     = IDX_W'(1);
                     lo_in    = '0;
                     state_in = S_FETCH;
                  end else begin
                     i_in     = '0;
                     state_in = S_ERD;
                  end
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = S_FETCH;
               end
            end else if (state_ff == S_PLACE) begin
               state_in = S_FETCH;
            end
         end
         S_ERD: begin
            rd_addr  = i_ff;
            state_in = S_EWR;
         end
         S_EWR: begin
            rd_addr = i_ff;
            if (!q_full) begin
               push.valid = 1'b1;
               if (at_end) begin
                  count_in = '0;
                  drop_in  = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = S_ERD;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
      n_ff     <= n_in;
      phase_ff <= phase_in;
      first_ff <= first_in;
      ax_ff    <= ax_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      lo_ff    <= lo_in;
      mov_ff   <= mov_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

`ifndef SYNTHESIS
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT) else $error("entry count above capacity");
   a_cmp_above_lo: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |-> j_ff > lo_ff) else $error("insertion ran past run start");
   a_last_stops_load: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready && in_last |=> !in_ready) else $error("load after frame end");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !q_full) else $error("push into full queue");
`endif

endmodule

// ===== rtl/dcps_queue.sv =====
`timescale 1ns / 1ps
module dcps_queue
   import dcps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  q_push_type push,
   output logic       full,
   output logic       out_valid,
   input  logic       out_ready,
   output res_type    out_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   res_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full      = cnt_ff == CNT_W'(QUEUE_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_data  = slot_ff[rptr_ff];
   assign do_push   = push.valid && !full;
   assign do_pop    = out_valid && out_ready;

   always_comb begin
      wptr_in = do_push ? PTR_W'((CNT_W'(wptr_ff) + CNT_W'(1)) % QUEUE_DEPTH) : wptr_ff;
      rptr_in = do_pop  ? PTR_W'((CNT_W'(rptr_ff) + CNT_W'(1)) % QUEUE_DEPTH) : rptr_ff;
      cnt_in  = cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (do_push) slot_ff[wptr_ff] <= push.data;
   end

`ifndef SYNTHESIS
   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(QUEUE_DEPTH)) else $error("queue count above depth");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> cnt_ff == $past(cnt_ff) + CNT_W'(1))
      else $error("queue count missed a push");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      do_pop && !do_push |=> cnt_ff == $past(cnt_ff) - CNT_W'(1))
      else $error("queue count missed a pop");
`endif

endmodule

// ===== rtl/detection_class_position_sorter.sv =====
`timescale 1ns / 1ps
// Loading: one detection per cycle. On the frame's last beat the store is sorted in place by
// insertion (fetch, move, then compare and shift per neighbour, then place), class pass then
// position pass within each class run, with one entry read per cycle. Results are then read
// and pushed in turn through a 4-entry queue, holding while the queue is full. Synchronous
// active-high reset clears state, counts, overflow flag and queue; entry memory is not cleared.
module detection_class_position_sorter
   import dcps_pkg::*;
#(
   parameter int MAX_DETECTIONS = MAX_DETECTIONS_DEF,
   parameter int COORD_BITS     = COORD_BITS_DEF,
   parameter int CLASS_BITS     = CLASS_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // class_id[7:0], pos_x[23:8], pos_y[39:24]
   input  logic                  req_tlast,  // last_in
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // out_x[15:0], out_y[31:16]
   output logic                  rsp_tlast,  // last_out
   output logic [0:0]            rsp_tuser   // overflow
);

   q_push_type push;
   logic       q_full;
   res_type    res;

   dcps_front #(
      .MAX_DETECTIONS(MAX_DETECTIONS),
      .COORD_BITS    (COORD_BITS),
      .CLASS_BITS    (CLASS_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .in_class(req_tdata[7:0]),
      .in_x    (req_tdata[23:8]),
      .in_y    (req_tdata[39:24]),
      .in_last (req_tlast),
      .push    (push),
      .q_full  (q_full)
   );

   dcps_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (q_full),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data (res)
   );

   assign rsp_tdata = {res.out_y, res.out_x};
   assign rsp_tlast = res.last_out;
   assign rsp_tuser = res.overflow;

endmodule

// ===== sim/detection_class_position_sorter_tb.sv =====
`timescale 1ns / 1ps
module detection_class_position_sorter_tb;
   import dcps_pkg::*;

   localparam int CAPACITY   = 32;
   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      logic [7:0]  cls;
      logic [15:0] px;
      logic [15:0] py;
   } det_type;

   typedef struct {
      logic [15:0] x;
      logic [15:0] y;
      logic        lst;
      logic        ovf;
   } pair_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // class_id[7:0], pos_x[23:8], pos_y[39:24]
   logic                  req_tlast = 1'b0; // last_in
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // out_x[15:0], out_y[31:16]
   logic                  rsp_tlast;        // last_out
   logic [0:0]            rsp_tuser;        // overflow

   det_type  frame_store[CAPACITY];
   int       frame_count = 0;
   bit       frame_dropped = 1'b0;
   pair_type sorted_pairs[$];

   int  mismatches = 0;
   int  idle_cycles = 0;
   bit  timed_out = 1'b0;
   bit  calm_mode = 1'b0;

   detection_class_position_sorter dut (.*);

   always #5 clock = ~clock;

   function automatic int pick_axis(int k);
      int dx, dy;
      dx = int'(frame_store[k-1].px) - int'(frame_store[k].px);
      dy = int'(frame_store[k-1].py) - int'(frame_store[k].py);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return (dy > dx) ? 1 : 0;
   endfunction

   function automatic logic [15:0] coord(int k, int ax);
      return ax ? frame_store[k].py : frame_store[k].px;
   endfunction

   function automatic void swap_down(int k);
      det_type t;
      t = frame_store[k];
      frame_store[k] = frame_store[k-1];
      frame_store[k-1] = t;
   endfunction

   function automatic void sort_by_position(int lo, int hi);
      int j, ax;
      for (int i = lo + 1; i < hi; i++) begin
         j = i;
         ax = pick_axis(j);
         while (j > lo && coord(j-1, ax) > coord(j, ax)) begin
            ax = pick_axis(j);
            swap_down(j);
            j--;
         end
      end
   endfunction

   // stores one detection; on last, sorts and queues the frame's pairs
   function automatic void predict_detection(det_type d, bit lst);
      int j, lo;
      pair_type p;
      if (frame_count < CAPACITY) begin
         frame_store[frame_count] = d;
         frame_count++;
      end else begin
         frame_dropped = 1'b1;
      end
      if (!lst) return;
      for (int i = 1; i < frame_count; i++) begin
         j = i;
         while (j > 0 && frame_store[j-1].cls > frame_store[j].cls) begin
            swap_down(j);
            j--;
         end
      end
      lo = 0;
      for (int k = 1; k <= frame_count; k++) begin
         if (k == frame_count || frame_store[k].cls != frame_store[lo].cls) begin
            if (k - lo >= 2) sort_by_position(lo, k);
            lo = k;
         end
      end
      for (int k = 0; k < frame_count; k++) begin
         p.x = frame_store[k].px;
         p.y = frame_store[k].py;
         p.lst = (k + 1 == frame_count);
         p.ovf = frame_dropped;
         sorted_pairs = {sorted_pairs, p};
      end
      frame_count = 0;
      frame_dropped = 1'b0;
   endfunction

   // tvalid stays high after the beat; the next call may drop it for idle beats, wait_drained drops it
   task automatic send_detection(logic [7:0] c, logic [15:0] x, logic [15:0] y, bit lst);
      det_type d;
      while (!calm_mode && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {y, x, c};
      req_tlast <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      d.cls = c;
      d.px = x;
      d.py = y;
      predict_detection(d, lst);
   endtask

   task automatic send_frame(int n, int cmax, int span);
      for (int i = 0; i < n; i++)
         send_detection(8'($urandom_range(cmax)), 16'($urandom_range(span)),
                        16'($urandom_range(span)), i == n - 1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sorted_pairs.size() != 0 && !timed_out) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) rsp_tready <= calm_mode || ($urandom_range(99) >= 8);
   end

   always @(posedge clock) begin
      pair_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (sorted_pairs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %h", rsp_tdata);
         end else begin
            e = sorted_pairs.pop_front();
            if (rsp_tdata[15:0] !== e.x || rsp_tdata[31:16] !== e.y ||
                rsp_tlast !== e.lst || rsp_tuser[0] !== e.ovf) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp x=%h y=%h last=%b ovf=%b, got x=%h y=%h last=%b ovf=%b",
                           e.x, e.y, e.lst, e.ovf, rsp_tdata[15:0], rsp_tdata[31:16],
                           rsp_tlast, rsp_tuser[0]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) timed_out <= 1'b1;
   end

   initial begin
      @(posedge timed_out);
      $display("detection_class_position_sorter test failed");
      $finish;
   end

   task automatic test_field_extremes();
      send_detection(8'hFF, 16'hFFFF, 16'h0000, 0);
      send_detection(8'h00, 16'h0000, 16'hFFFF, 0);
      send_detection(8'hFF, 16'h0000, 16'h0000, 0);
      send_detection(8'h00, 16'hFFFF, 16'hFFFF, 1);
      send_detection(8'h55, 16'h1234, 16'hABCD, 1);   // single-entry frame
   endtask

   task automatic test_ties_and_axes();
      send_detection(8'd3, 16'd100, 16'd100, 0);      // equal coords: order kept
      send_detection(8'd3, 16'd100, 16'd100, 0);
      send_detection(8'd3, 16'd50, 16'd150, 0);       // |dy| == |dx| picks x
      send_detection(8'd3, 16'd60, 16'd900, 0);       // y dominates
      send_detection(8'd1, 16'd7, 16'd7, 0);
      send_detection(8'd9, 16'd500, 16'd10, 0);       // run of two at end
      send_detection(8'd9, 16'd400, 16'd20, 1);
   endtask

   task automatic test_overflow();
      for (int i = 0; i < CAPACITY + 3; i++)
         send_detection(8'($urandom_range(3)), 16'($urandom), 16'($urandom),
                        i == CAPACITY + 2);
      wait_drained();
      for (int i = 0; i < CAPACITY; i++)            // full exactly, no drop
         send_detection(8'($urandom_range(255)), 16'($urandom), 16'($urandom),
                        i == CAPACITY - 1);
   endtask

   task automatic test_random_frames();
      int sent, n;
      sent = 0;
      while (sent < 350) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(CAPACITY + 4, 20)
                                      : $urandom_range(10, 1);
         case ($urandom_range(2))
            0: send_frame(n, 3, 65535);
            1: send_frame(n, 255, 65535);
            default: send_frame(n, 1, 15);              // many coordinate ties
         endcase
         sent += n;
         if ($urandom_range(7) == 0) wait_drained();
      end
   endtask

   task automatic test_no_idling();
      calm_mode = 1'b1;
      for (int f = 0; f < 6; f++) send_frame($urandom_range(12, 2), 2, 65535);
      calm_mode = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_ties_and_axes();
      wait_drained();
      test_overflow();
      test_no_idling();
      test_random_frames();
      wait_drained();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && sorted_pairs.size() == 0)
         $display("detection_class_position_sorter test passed");
      else
         $display("detection_class_position_sorter test failed");
      $finish;
   end

endmodule
